>>> hw/rtl/gmhr_pkg.sv
package gmhr_pkg;
    localparam int GRID_MAX_DEF    = 64;
    localparam int HEIGHT_BITS_DEF = 8;
    localparam int SIDE_W          = 7;
endpackage

>>> hw/rtl/grid_min_height_range_path_core.sv
// Grid minimum height-range path core. Load a square grid of heights in raster order, one cell
// per start transaction (busy stays low while loading, one cell per cycle). After the last cell
// the core computes the smallest max-minus-min height over all 4-connected paths from the
// top-left to the bottom-right cell, and pulses o_valid with o_min_range for exactly one cycle;
// the receiver cannot stall it. While the search runs, busy is high. The search steps through the
// single-port height, visited and queue memories: a scan of the n*n cells, then per binary-search
// trial a trial step, and per candidate lower bound a setup step, a visited-map clear of the n*n
// cells, a seed of the start cell, for each cell taken off the queue a pop, a goal check and a
// read and a write for each of its four neighbors, an empty-queue check and a step to move on.
// A final done state emits the result.
// Writing i_cfg_data sets the side (0 is taken as 1, above GRID_MAX as GRID_MAX) and restarts
// loading; o_cfg_ready is high only while loading and no start transaction is offered.
module grid_min_height_range_path_core
    import gmhr_pkg::*;
#(
    parameter int GRID_MAX    = GRID_MAX_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [HEIGHT_BITS-1:0] i_cell_height,
    output logic                   o_valid,
    output logic [HEIGHT_BITS-1:0] o_min_range,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [SIDE_W-1:0]      i_cfg_data
);
    localparam int CELLS = GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = AW + 1;
    localparam int RW    = $clog2(GRID_MAX);
    localparam int QW    = 2 * RW;
    localparam int NW    = $clog2(GRID_MAX + 1);
    localparam int LEVELS = 1 << HEIGHT_BITS;
    localparam int HB1   = HEIGHT_BITS + 1;

    typedef enum logic [3:0] {
        S_LOAD, S_SCAN, S_SCAN_W, S_TRIAL, S_LEVEL, S_CLEAR, S_START, S_START_W,
        S_POP, S_POP_W, S_NBR, S_NBR_W, S_NEXT, S_DONE
    } t_state;

    t_state r_state;
    logic [SIDE_W-1:0]      r_side;
    logic [CW-1:0]          r_cnt;
    logic [HEIGHT_BITS-1:0] r_maxh, r_sth, r_best, r_mid, r_x;
    logic [HB1-1:0]         r_lo, r_hi;
    logic [LEVELS-1:0]      r_lvl;
    logic [CW-1:0]          r_head, r_tail;
    logic [RW-1:0]          r_pr, r_pc;
    logic [RW-1:0]          r_nr, r_nc;
    logic [AW-1:0]          r_q;
    logic [2:0]             r_k;
    logic                   r_qok;

    // memories, the queue holds row and column of each queued cell
    logic [HEIGHT_BITS-1:0] m_h [CELLS];
    logic                   m_v [CELLS];
    logic [QW-1:0]          m_q [CELLS];
    logic [HEIGHT_BITS-1:0] r_hrd;
    logic                   r_vrd;
    logic [QW-1:0]          r_qrd;

    logic [NW-1:0] n_side;
    logic [CW-1:0] total;
    always_comb begin
        if (r_side == '0) n_side = NW'(1);
        else if (32'(r_side) > GRID_MAX) n_side = NW'(GRID_MAX);
        else n_side = NW'(r_side);
        total = CW'(n_side * n_side);
    end

    // memory ports driven by state
    logic [AW-1:0] h_addr, v_addr, q_raddr;
    logic          h_we, v_we, v_wd, q_we;
    logic [HEIGHT_BITS-1:0] h_wd;
    logic [AW-1:0] nb_addr;
    logic [RW:0]   nr, nc;
    logic          nb_ok;
    logic [HB1-1:0] hiband;
    logic [RW-1:0] last_rc;

    always_comb begin
        nr = {1'b0, r_pr};
        nc = {1'b0, r_pc};
        case (r_k)
            3'd0: nr = nr - 1'b1;
            3'd1: nc = nc - 1'b1;
            3'd2: nc = nc + 1'b1;
            default: nr = nr + 1'b1;
        endcase
        nb_ok = !nr[RW] && !nc[RW] && (NW'(nr) < n_side) && (NW'(nc) < n_side)
                && !(r_k == 3'd0 && r_pr == '0) && !(r_k == 3'd1 && r_pc == '0);
        nb_addr = AW'(nr * n_side + nc);
        hiband = HB1'(r_x) + HB1'(r_mid);
        last_rc = RW'(n_side - NW'(1));
    end

    always_comb begin
        h_addr = AW'(r_cnt);
        h_we = 1'b0; h_wd = i_cell_height;
        v_addr = AW'(r_cnt); v_we = 1'b0; v_wd = 1'b0;
        q_we = 1'b0; q_raddr = AW'(r_head);
        unique case (r_state)
            S_LOAD:  h_we = start;
            S_CLEAR: v_we = 1'b1;
            S_START: begin h_addr = '0; end
            S_START_W: begin v_addr = '0; v_wd = 1'b1; end
            S_NBR: begin h_addr = nb_addr; v_addr = nb_addr; end
            S_NBR_W: begin v_addr = r_q; v_wd = 1'b1; end
            default: ;
        endcase
        if (r_state == S_START_W) v_we = (r_hrd >= r_x) && (HB1'(r_hrd) <= hiband);
        if (r_state == S_NBR_W)
            v_we = r_qok && !r_vrd && (r_hrd >= r_x) && (HB1'(r_hrd) <= hiband);
        q_we = v_we && (r_state == S_START_W || r_state == S_NBR_W);
    end

    always_ff @(posedge i_clk) begin
        if (h_we) m_h[h_addr] <= h_wd;
        r_hrd <= m_h[h_addr];
        if (v_we) m_v[v_addr] <= v_wd;
        r_vrd <= m_v[v_addr];
        if (q_we) m_q[AW'(r_tail)] <= (r_state == S_START_W) ? '0 : {r_nr, r_nc};
        r_qrd <= m_q[q_raddr];
    end

    assign busy = (r_state != S_LOAD);
    // side writes wait while a cell is offered
    assign o_cfg_ready = (r_state == S_LOAD) && !start;

    // lowest candidate lower-bound level (priority search over level bits)
    logic [HEIGHT_BITS-1:0] first_lvl;
    logic                   has_lvl;
    always_comb begin
        first_lvl = '0; has_lvl = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--)
            if (r_lvl[i]) begin first_lvl = HEIGHT_BITS'(i); has_lvl = 1'b1; end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_side <= SIDE_W'(1); r_cnt <= '0; r_maxh <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_side <= i_cfg_data; r_cnt <= '0; r_maxh <= '0;
                    end else if (start) begin
                        if (i_cell_height > r_maxh) r_maxh <= i_cell_height;
                        if (r_cnt + 1'b1 >= total) begin
                            if (i_cell_height > r_maxh) r_best <= i_cell_height;
                            else r_best <= r_maxh;
                            r_cnt <= '0; r_lvl <= '0;
                            r_state <= S_SCAN;
                        end else r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SCAN: r_state <= S_SCAN_W;       // read cell r_cnt
                S_SCAN_W: begin
                    if (r_cnt == '0) r_sth <= r_hrd;
                    if (r_cnt == '0 || r_hrd <= r_sth) r_lvl[r_hrd] <= 1'b1;
                    if (r_cnt + 1'b1 >= total) begin
                        r_lo <= '0; r_hi <= HB1'(r_best); r_state <= S_TRIAL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1; r_state <= S_SCAN;
                    end
                end
                S_TRIAL: begin
                    if (r_lo > r_hi) r_state <= S_DONE;
                    else begin
                        r_mid <= HEIGHT_BITS'((r_lo + r_hi) >> 1);
                        r_x <= first_lvl;
                        r_state <= has_lvl ? S_LEVEL : S_NEXT;
                        r_qok <= 1'b0;
                    end
                end
                S_LEVEL: begin r_cnt <= '0; r_state <= S_CLEAR; end
                S_CLEAR: begin
                    if (r_cnt + 1'b1 >= total) r_state <= S_START;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_START: begin r_head <= '0; r_tail <= '0; r_state <= S_START_W; end
                S_START_W: begin
                    if (v_we) begin r_tail <= CW'(1); r_state <= S_POP; end
                    else r_state <= S_NEXT;
                end
                S_POP: begin
                    if (r_head >= r_tail) r_state <= S_NEXT;
                    else r_state <= S_POP_W;
                end
                S_POP_W: begin
                    if (r_qrd[QW-1:RW] == last_rc && r_qrd[RW-1:0] == last_rc) begin
                        r_qok <= 1'b1; r_state <= S_NEXT;
                    end else begin
                        r_pr <= r_qrd[QW-1:RW]; r_pc <= r_qrd[RW-1:0];
                        r_k <= '0; r_head <= r_head + 1'b1; r_state <= S_NBR;
                    end
                end
                S_NBR: begin
                    r_q <= nb_addr;
                    r_nr <= RW'(nr);
                    r_nc <= RW'(nc);
                    r_qok <= nb_ok;
                    r_state <= S_NBR_W;
                end
                S_NBR_W: begin
                    if (q_we) r_tail <= r_tail + 1'b1;
                    r_qok <= 1'b0;
                    if (r_k == 3'd3) r_state <= S_POP;
                    else begin r_k <= r_k + 1'b1; r_state <= S_NBR; end
                end
                S_NEXT: begin
                    if (r_qok) begin
                        r_best <= r_mid; r_qok <= 1'b0;
                        // a zero range that works ends the search
                        if (r_mid == '0) r_state <= S_DONE;
                        else begin
                            r_hi <= HB1'(r_mid) - 1'b1; r_state <= S_TRIAL;
                        end
                    end else begin
                        logic [HEIGHT_BITS-1:0] nx;
                        logic                   found;
                        nx = '0; found = 1'b0;
                        for (int i = LEVELS - 1; i >= 0; i--)
                            if (r_lvl[i] && HEIGHT_BITS'(i) > r_x) begin
                                nx = HEIGHT_BITS'(i); found = 1'b1;
                            end
                        if (found && r_state == S_NEXT && r_head != '1 && nx > r_x &&
                            !(r_x == first_lvl && !has_lvl)) begin
                            r_x <= nx; r_state <= S_LEVEL;
                        end else begin
                            r_lo <= HB1'(r_mid) + 1'b1; r_state <= S_TRIAL;
                        end
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1; o_min_range <= r_best;
                    r_cnt <= '0; r_maxh <= '0; r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // result strobe only leaves the done state
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_DONE) else $error("stray result");
    // no load while searching
    a_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> busy) else $error("busy low during search");
endmodule
